/* rtl/cccm_pkg.sv */
// shared types and constants for the channel compensation / mrc core
// no dependencies
package cccm_pkg;

    localparam int unsigned SMP_W      = 16;
    localparam int unsigned ACC_W      = 32;
    localparam int unsigned SHIFT_W    = 5;
    localparam int unsigned CFG_IDX_W  = 4;
    localparam int unsigned CFG_DATA_W = 5;
    localparam int unsigned PIPE_DEPTH = 4;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_SHIFT   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TWO_RX_ENABLE = 4'd1;

    typedef struct packed {
        logic signed [SMP_W-1:0] re;
        logic signed [SMP_W-1:0] im;
    } t_cplx16;

    typedef struct packed {
        logic signed [ACC_W-1:0] re;
        logic signed [ACC_W-1:0] im;
    } t_cplx32;

endpackage

/* rtl/conj_channel_compensation_mrc_core.sv */
// top level of the matched-filter channel compensation core with mrc
// depends on cccm_pkg, cccm_cmul, cccm_scale
//
// One request is one resource element: received samples and channel estimates
// for two antennas. The core returns conj(h)*y per antenna, shifted right by
// the configured shift amount and saturated to 16 bits, plus the maximal-ratio
// combination (halved antenna results added with saturation) when two_rx_enable
// is set; with one antenna comp1 reads zero and the combined output equals
// antenna 0. The pipeline has four stages (products, 32-bit sums, shift and
// saturate, combine into the output register), and one request is taken every
// cycle while the output is not stalled. The whole pipe advances together and
// holds while a finished result is not taken, so o_ready is high whenever the
// output register is empty or being taken. Configuration must be written only
// while the core is idle; the core itself does not enforce this.
module conj_channel_compensation_mrc_core import cccm_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // configuration port
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    // input channel
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic signed [SMP_W-1:0] i_rx0_re,
    input  logic signed [SMP_W-1:0] i_rx0_im,
    input  logic signed [SMP_W-1:0] i_rx1_re,
    input  logic signed [SMP_W-1:0] i_rx1_im,
    input  logic signed [SMP_W-1:0] i_ch0_re,
    input  logic signed [SMP_W-1:0] i_ch0_im,
    input  logic signed [SMP_W-1:0] i_ch1_re,
    input  logic signed [SMP_W-1:0] i_ch1_im,
    // output channel
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic signed [SMP_W-1:0] o_comp0_re,
    output logic signed [SMP_W-1:0] o_comp0_im,
    output logic signed [SMP_W-1:0] o_comp1_re,
    output logic signed [SMP_W-1:0] o_comp1_im,
    output logic signed [SMP_W-1:0] o_combined_re,
    output logic signed [SMP_W-1:0] o_combined_im
);

    // configuration registers
    logic [SHIFT_W-1:0] r_out_shift;
    logic               r_two_rx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_shift <= '0;
            r_two_rx    <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SCALE_SHIFT:   r_out_shift <= i_cfg_data[SHIFT_W-1:0];
                CFG_TWO_RX_ENABLE: r_two_rx    <= i_cfg_data[0];
                default: ;  // index beyond the list: ignored
            endcase
        end
    end

    // global pipeline enable: advance unless a finished result is stalled
    logic pipe_en;
    assign pipe_en = !o_valid || i_ready;
    assign o_ready = pipe_en;

    // valid bits travel alongside the data, last one is the output register
    logic [PIPE_DEPTH-1:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (pipe_en) begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], i_valid};
        end
    end

    assign o_valid = r_vld[PIPE_DEPTH-1];

    // per-antenna datapaths
    t_cplx16 y0, y1, h0, h1;
    t_cplx32 sum0, sum1;
    t_cplx16 val0, val1;

    assign y0 = '{re: i_rx0_re, im: i_rx0_im};
    assign y1 = '{re: i_rx1_re, im: i_rx1_im};
    assign h0 = '{re: i_ch0_re, im: i_ch0_im};
    assign h1 = '{re: i_ch1_re, im: i_ch1_im};

    cccm_cmul u_cmul0 (.i_clk(i_clk), .i_en(pipe_en), .i_y(y0), .i_h(h0), .o_sum(sum0));
    cccm_cmul u_cmul1 (.i_clk(i_clk), .i_en(pipe_en), .i_y(y1), .i_h(h1), .o_sum(sum1));

    cccm_scale u_scale0 (
        .i_clk(i_clk), .i_en(pipe_en), .i_shift(r_out_shift), .i_sum(sum0), .o_val(val0)
    );
    cccm_scale u_scale1 (
        .i_clk(i_clk), .i_en(pipe_en), .i_shift(r_out_shift), .i_sum(sum1), .o_val(val1)
    );

    // combine stage: halve each antenna, add with 16-bit saturation
    function automatic logic signed [SMP_W-1:0] sat_add_half(
        input logic signed [SMP_W-1:0] a,
        input logic signed [SMP_W-1:0] b
    );
        logic signed [SMP_W:0]   s;
        logic signed [SMP_W-1:0] res;
        s = {{2{a[SMP_W-1]}}, a[SMP_W-1:1]} + {{2{b[SMP_W-1]}}, b[SMP_W-1:1]};
        if (s[SMP_W] == s[SMP_W-1]) begin
            res = s[SMP_W-1:0];
        end else if (s[SMP_W]) begin
            res = {1'b1, {(SMP_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(SMP_W-1){1'b1}}};
        end
        return res;
    endfunction

    t_cplx16 n_comp1, n_comb;
    t_cplx16 r_comp0, r_comp1, r_comb;

    always_comb begin
        if (r_two_rx) begin
            n_comp1    = val1;
            n_comb.re  = sat_add_half(val0.re, val1.re);
            n_comb.im  = sat_add_half(val0.im, val1.im);
        end else begin
            // single antenna: antenna 1 reads zero, combined is antenna 0
            n_comp1    = '0;
            n_comb     = val0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_comp0 <= val0;
            r_comp1 <= n_comp1;
            r_comb  <= n_comb;
        end
    end

    assign o_comp0_re    = r_comp0.re;
    assign o_comp0_im    = r_comp0.im;
    assign o_comp1_re    = r_comp1.re;
    assign o_comp1_im    = r_comp1.im;
    assign o_combined_re = r_comb.re;
    assign o_combined_im = r_comb.im;

    // checks
    a_single_rx_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !r_two_rx) |->
            (o_comp1_re == '0 && o_comp1_im == '0 &&
             o_combined_re == o_comp0_re && o_combined_im == o_comp0_im))
        else $error("single antenna output mismatch");

    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_valid)
        else $error("result valid straight after reset");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_valid && o_ready, 4) && $past(i_rst_n, 4) &&
         $past(i_rst_n, 3) && $past(i_rst_n, 2) && $past(i_rst_n, 1) &&
         $past(i_ready, 3) && $past(i_ready, 2) && $past(i_ready, 1)) |-> o_valid)
        else $error("accepted request did not reach the output");

endmodule

/* rtl/cccm_cmul.sv */
// conj(h)*y for one antenna: product stage then 32-bit wrapping sum stage
// depends on cccm_pkg
module cccm_cmul import cccm_pkg::*; (
    input  logic    i_clk,
    input  logic    i_en,
    input  t_cplx16 i_y,
    input  t_cplx16 i_h,
    output t_cplx32 o_sum
);

    logic signed [ACC_W-1:0] r_p_rr, r_p_ii, r_p_ri, r_p_ir;
    t_cplx32                 r_sum;

    // stage 1: four 16x16 products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p_rr <= i_h.re * i_y.re;
            r_p_ii <= i_h.im * i_y.im;
            r_p_ri <= i_h.re * i_y.im;
            r_p_ir <= i_h.im * i_y.re;
        end
    end

    // stage 2: sums wrap in 32 bits
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum.re <= r_p_rr + r_p_ii;
            r_sum.im <= r_p_ri - r_p_ir;
        end
    end

    assign o_sum = r_sum;

endmodule

/* rtl/cccm_scale.sv */
// arithmetic right shift and 16-bit saturation, one register stage
// depends on cccm_pkg
module cccm_scale import cccm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [SHIFT_W-1:0] i_shift,
    input  t_cplx32            i_sum,
    output t_cplx16            o_val
);

    function automatic logic signed [SMP_W-1:0] sat16(input logic signed [ACC_W-1:0] v);
        logic signed [SMP_W-1:0] res;
        if (v[ACC_W-1:SMP_W-1] == '0 || v[ACC_W-1:SMP_W-1] == '1) begin
            res = v[SMP_W-1:0];
        end else if (v[ACC_W-1]) begin
            res = {1'b1, {(SMP_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(SMP_W-1){1'b1}}};
        end
        return res;
    endfunction

    logic signed [ACC_W-1:0] shr_re, shr_im;
    t_cplx16                 r_val;

    assign shr_re = i_sum.re >>> i_shift;
    assign shr_im = i_sum.im >>> i_shift;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_val.re <= sat16(shr_re);
            r_val.im <= sat16(shr_im);
        end
    end

    assign o_val = r_val;

endmodule
